// ===== sv/mbud_pkg.sv =====
// ----------------------------------------------------------------------------
// mbud_pkg
// Shared types and constants of the masked bit unpack dequantizer.
// ----------------------------------------------------------------------------
package mbud_pkg;

	// Configuration register indexes.
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_CODE_WIDTH  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_SLOT_COUNT  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_BASE_OFFSET = 2'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_STEP_SIZE   = 2'd3;
	localparam int CFG_DATA_W = 32;

	// Reset values of the configuration registers.
	localparam logic [4:0]         RST_CODE_WIDTH  = 5'd8;
	localparam logic [8:0]         RST_SLOT_COUNT  = 9'd256;
	localparam logic signed [31:0] RST_BASE_OFFSET = 32'sd0;
	localparam logic signed [31:0] RST_STEP_SIZE   = 32'sd65536;

	// Input word kinds.
	localparam logic FUNC_MASK = 1'b0;
	localparam logic FUNC_DATA = 1'b1;

	// At most this many codes are unpacked from one data word.
	localparam logic [5:0] MAX_CODES_PER_WORD = 6'd32;

	localparam logic signed [63:0] SAT_MAX = 64'sd2147483647;
	localparam logic signed [63:0] SAT_MIN = -64'sd2147483648;

	typedef struct packed {
		logic [4:0]         code_width;
		logic [8:0]         slot_count;
		logic signed [31:0] base_offset;
		logic signed [31:0] step_size;
	} cfg_t;

	typedef enum logic [1:0] {
		OP_MASK_FIRST = 2'd0,
		OP_MASK_NEXT  = 2'd1,
		OP_DATA       = 2'd2
	} op_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] word;
	} queue_item_t;

	// A zero code width behaves as a width of one.
	function automatic logic [4:0] eff_width(input logic [4:0] code_width);
		return (code_width == 5'd0) ? 5'd1 : code_width;
	endfunction

endpackage

// ===== sv/mbud_ifs.sv =====
// ----------------------------------------------------------------------------
// mbud_in_if / mbud_out_if
// Valid/ready stream channels of the masked bit unpack dequantizer.
// ----------------------------------------------------------------------------
interface mbud_in_if;
	logic        valid;
	logic        ready;
	logic        func;
	logic [31:0] word;

	modport source (output valid, output func, output word, input ready);
	modport sink (input valid, input func, input word, output ready);
endinterface

interface mbud_out_if;
	logic               valid;
	logic               ready;
	logic [7:0]         slot_index;
	logic signed [31:0] value;
	logic               last;
	logic [10:0]        bytes_used;

	modport source (output valid, output slot_index, output value, output last,
		output bytes_used, input ready);
	modport sink (input valid, input slot_index, input value, input last,
		input bytes_used, output ready);
endinterface

// ===== sv/mbud_ram.sv =====
// ----------------------------------------------------------------------------
// mbud_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module mbud_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8
) (
	input  logic                                       clk,
	input  logic                                       we,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                           wdata,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                           rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== sv/mbud_queue.sv =====
// ----------------------------------------------------------------------------
// mbud_queue
// Short FIFO of classified words between the front and the back end.
// ----------------------------------------------------------------------------
module mbud_queue #(
	parameter int DEPTH = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  push,
	input  mbud_pkg::queue_item_t push_item,
	output logic                  full,
	input  logic                  pop,
	output mbud_pkg::queue_item_t pop_item,
	output logic                  nonempty
);
	import mbud_pkg::*;

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	queue_item_t      slots_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             do_push;
	logic             do_pop;

	assign full     = (count_q == CNT_W'(DEPTH));
	assign nonempty = (count_q != '0);
	assign pop_item = slots_q[rd_ptr_q];
	assign do_push  = push && !full;
	assign do_pop   = pop && nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (do_push && !do_pop) begin
				count_q <= count_q + CNT_W'(1);
			end else if (do_pop && !do_push) begin
				count_q <= count_q - CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (do_push) begin
			slots_q[wr_ptr_q] <= push_item;
		end
	end

endmodule

// ===== sv/mbud_front.sv =====
// ----------------------------------------------------------------------------
// mbud_front
// Accepts input words, tracks mask progress and classifies each word.
// ----------------------------------------------------------------------------
module mbud_front #(
	parameter int LW = 4
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic [LW-1:0]         needed,
	mbud_in_if.sink               din,
	output logic                  push,
	output mbud_pkg::queue_item_t push_item,
	input  logic                  q_full
);
	import mbud_pkg::*;

	logic [LW-1:0] loaded_q;
	logic          is_mask;
	logic          mask_done;
	logic          accept;

	assign din.ready = !q_full;

	always_comb begin
		is_mask   = (din.func == FUNC_MASK);
		mask_done = (loaded_q >= needed);
		accept    = din.valid && din.ready;
		// Data words that arrive before the mask is complete are dropped here.
		push      = accept && (is_mask || mask_done);
		if (!is_mask) begin
			push_item.op = OP_DATA;
		end else if (mask_done) begin
			push_item.op = OP_MASK_FIRST;
		end else begin
			push_item.op = OP_MASK_NEXT;
		end
		push_item.word = din.word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q <= '0;
		end else if (accept && is_mask) begin
			loaded_q <= mask_done ? LW'(1) : loaded_q + LW'(1);
		end
	end

endmodule

// ===== sv/mbud_back.sv =====
// ----------------------------------------------------------------------------
// mbud_back
// Stores the mask, walks the slots, unpacks codes and dequantizes them.
// ----------------------------------------------------------------------------
module mbud_back #(
	parameter int MAX_SLOTS = 256,
	parameter int PW        = 9
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  mbud_pkg::cfg_t        cfg,
	input  logic [PW-1:0]         n_slots,
	input  logic                  q_valid,
	input  mbud_pkg::queue_item_t q_item,
	output logic                  q_ready,
	mbud_out_if.source            dout
);
	import mbud_pkg::*;

	localparam int MASK_WORDS = (MAX_SLOTS + 31) / 32;
	localparam int AW         = (MASK_WORDS > 1) ? $clog2(MASK_WORDS) : 1;

	typedef enum logic [2:0] {
		ST_IDLE  = 3'b001,
		ST_SCAN  = 3'b010,
		ST_FETCH = 3'b100
	} state_t;

	state_t             st_q;
	logic [PW-1:0]      slot_pos_q;
	logic [PW-1:0]      present_q;
	logic [30:0]        lbits_q;
	logic [4:0]         lcount_q;
	logic [62:0]        acc_q;
	logic [5:0]         avail_q;
	logic [5:0]         cnt_q;
	logic [AW-1:0]      wptr_q;
	logic [31:0]        cache_q;
	logic [AW-1:0]      cache_idx_q;
	logic               cache_v_q;
	logic               pend_v_q;
	logic [PW-1:0]      pend_slot_q;
	logic [30:0]        pend_code_q;

	logic               s1_v_q;
	logic [7:0]         slot_s1;
	logic signed [63:0] prod_s1;
	logic               last_s1;
	logic [10:0]        bytes_s1;
	logic               out_v_q;
	logic [7:0]         slot_s2;
	logic signed [31:0] value_s2;
	logic               last_s2;
	logic [10:0]        bytes_s2;

	logic [4:0]         w;
	logic [PW-1:0]      pos_word;
	logic               at_end;
	logic               hit;
	logic               mbit;
	logic               found;
	logic               s1_ready;
	logic               s2_ready;
	logic               step_go;
	logic               emit;
	logic               take;
	logic               pop;
	logic [30:0]        lbits_m;
	logic [62:0]        acc_init;
	logic               ram_we;
	logic [AW-1:0]      ram_waddr;
	logic [AW-1:0]      ram_raddr;
	logic [31:0]        ram_rdata;
	logic [PW+4:0]      pbits;
	logic [31:0]        bsum;
	logic [31:0]        slot32;
	logic signed [63:0] prod;
	logic signed [63:0] sum;

	mbud_ram #(
		.WIDTH (32),
		.DEPTH (MASK_WORDS)
	) u_mask_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (q_item.word),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	always_comb begin
		w        = eff_width(cfg.code_width);
		pos_word = slot_pos_q >> 5;
		at_end   = (slot_pos_q >= n_slots);
		hit      = cache_v_q && (cache_idx_q == pos_word[AW-1:0]);
		mbit     = cache_q[slot_pos_q[4:0]];
		// A clear mask bit marks a present slot.
		found    = at_end || (hit && !mbit);
		s2_ready = !out_v_q || dout.ready;
		s1_ready = !s1_v_q || s2_ready;
		// The pending code is sent only once the next present slot is known,
		// since that decides whether it is the last one.
		step_go  = (st_q == ST_SCAN) && found && (!pend_v_q || s1_ready);
		emit     = step_go && pend_v_q;
		take     = step_go && !at_end && (avail_q >= {1'b0, w})
			&& (cnt_q < MAX_CODES_PER_WORD);
		q_ready  = (st_q == ST_IDLE);
		pop      = q_valid && q_ready;
		lbits_m  = lbits_q & ~(31'h7FFFFFFF << lcount_q);
		acc_init = {32'd0, lbits_m} | ({31'd0, q_item.word} << lcount_q);
		ram_we    = pop && (q_item.op != OP_DATA);
		ram_waddr = (q_item.op == OP_MASK_FIRST) ? '0 : wptr_q;
		ram_raddr = pos_word[AW-1:0];
		pbits     = (PW + 5)'(present_q) * (PW + 5)'(w);
		bsum      = 32'(n_slots >> 3) + ((32'(pbits) + 32'd7) >> 3);
		slot32    = 32'(pend_slot_q);
		prod      = $signed({1'b0, pend_code_q}) * cfg.step_size;
		sum       = 64'(cfg.base_offset) + prod_s1;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_IDLE;
			slot_pos_q  <= '0;
			present_q   <= '0;
			lbits_q     <= '0;
			lcount_q    <= '0;
			acc_q       <= '0;
			avail_q     <= '0;
			cnt_q       <= '0;
			wptr_q      <= '0;
			cache_q     <= '0;
			cache_idx_q <= '0;
			cache_v_q   <= 1'b0;
			pend_v_q    <= 1'b0;
			pend_slot_q <= '0;
			pend_code_q <= '0;
		end else begin
			case (st_q)
				ST_IDLE: begin
					if (pop) begin
						if (q_item.op == OP_DATA) begin
							acc_q   <= acc_init;
							avail_q <= {1'b0, lcount_q} + 6'd32;
							cnt_q   <= '0;
							st_q    <= ST_SCAN;
						end else begin
							cache_v_q <= 1'b0;
							if (q_item.op == OP_MASK_FIRST) begin
								// A mask word after a complete mask opens a new block.
								wptr_q     <= AW'(1);
								slot_pos_q <= '0;
								present_q  <= '0;
								lbits_q    <= '0;
								lcount_q   <= '0;
							end else begin
								wptr_q <= wptr_q + AW'(1);
							end
						end
					end
				end
				ST_SCAN: begin
					if (step_go) begin
						if (take) begin
							pend_v_q    <= 1'b1;
							pend_slot_q <= slot_pos_q;
							pend_code_q <= acc_q[30:0] & ~(31'h7FFFFFFF << w);
							acc_q       <= acc_q >> w;
							avail_q     <= avail_q - {1'b0, w};
							present_q   <= present_q + PW'(1);
							cnt_q       <= cnt_q + 6'd1;
							slot_pos_q  <= slot_pos_q + PW'(1);
						end else begin
							pend_v_q <= 1'b0;
							st_q     <= ST_IDLE;
							if (at_end) begin
								slot_pos_q <= n_slots;
								lbits_q    <= '0;
								lcount_q   <= '0;
							end else begin
								lbits_q  <= acc_q[30:0];
								lcount_q <= avail_q[4:0];
							end
						end
					end else if (!at_end && hit && mbit) begin
						slot_pos_q <= slot_pos_q + PW'(1);
					end else if (!at_end && !hit) begin
						st_q <= ST_FETCH;
					end
				end
				ST_FETCH: begin
					cache_q     <= ram_rdata;
					cache_idx_q <= pos_word[AW-1:0];
					cache_v_q   <= 1'b1;
					st_q        <= ST_SCAN;
				end
				default: begin
					st_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_ready) begin
				s1_v_q <= emit;
			end
			if (s2_ready) begin
				out_v_q <= s1_v_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_ready && emit) begin
			slot_s1  <= slot32[7:0];
			prod_s1  <= prod;
			last_s1  <= at_end;
			bytes_s1 <= at_end ? bsum[10:0] : 11'd0;
		end
		if (s2_ready && s1_v_q) begin
			slot_s2  <= slot_s1;
			last_s2  <= last_s1;
			bytes_s2 <= bytes_s1;
			if (sum > SAT_MAX) begin
				value_s2 <= 32'sh7FFFFFFF;
			end else if (sum < SAT_MIN) begin
				value_s2 <= 32'sh80000000;
			end else begin
				value_s2 <= sum[31:0];
			end
		end
	end

	assign dout.valid      = out_v_q;
	assign dout.slot_index = slot_s2;
	assign dout.value      = value_s2;
	assign dout.last       = last_s2;
	assign dout.bytes_used = bytes_s2;

endmodule

// ===== sv/masked_bit_unpack_dequantizer_unit.sv =====
// ----------------------------------------------------------------------------
// masked_bit_unpack_dequantizer_unit
// Unpacks masked, variable-width quantized codes and dequantizes them.
// ----------------------------------------------------------------------------
// Usage: write the four registers through cfg_we/cfg_index/cfg_wdata while
// the block is idle. Then send the mask words (func 0) followed by the packed
// data words (func 1) on din. Each present slot yields one transfer on dout
// with its index and base_offset + code * step_size, saturated; the final
// present slot carries last and the byte count.
// Back end: a mask word is written to the mask RAM from idle. A data word is
// started from idle; the slot walk then visits each slot, present or
// skipped, holds while the RAM is read each time it enters a new mask word,
// and returns to idle when it finishes. A code waits until the walk has
// found the next present slot or the end of the block, since that decides
// last; it then passes a multiply stage and an add and saturate stage,
// each registered, before it reaches dout. The slot walk of one slot per
// cycle sets the rate while the walk is not held by a mask RAM read or a
// stalled dout.
// A small queue lets din keep transferring while the back end works or dout
// is stalled; when the receiver stalls, the queue fills and din.ready falls.
// Reset clears all counters and the queue and loads the register defaults.
// ----------------------------------------------------------------------------
module masked_bit_unpack_dequantizer_unit #(
	parameter int MAX_SLOTS   = 256,
	parameter int QUEUE_DEPTH = 4
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [mbud_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [mbud_pkg::CFG_DATA_W-1:0] cfg_wdata,
	mbud_in_if.sink                        din,
	mbud_out_if.source                     dout
);
	import mbud_pkg::*;

	localparam int MASK_WORDS = (MAX_SLOTS + 31) / 32;
	localparam int LW         = $clog2(MASK_WORDS + 1);
	localparam int PW         = ($clog2(MAX_SLOTS + 1) < 6) ? 6 : $clog2(MAX_SLOTS + 1);

	cfg_t          cfg_q;
	logic [31:0]   rnd;
	logic [31:0]   words_needed;
	logic [PW-1:0] n_slots;
	logic [LW-1:0] needed;
	logic          q_push;
	queue_item_t   q_push_item;
	logic          q_full;
	logic          q_pop;
	queue_item_t   q_pop_item;
	logic          q_nonempty;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.code_width  <= RST_CODE_WIDTH;
			cfg_q.slot_count  <= RST_SLOT_COUNT;
			cfg_q.base_offset <= RST_BASE_OFFSET;
			cfg_q.step_size   <= RST_STEP_SIZE;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CODE_WIDTH:  cfg_q.code_width  <= cfg_wdata[4:0];
				CFG_SLOT_COUNT:  cfg_q.slot_count  <= cfg_wdata[8:0];
				CFG_BASE_OFFSET: cfg_q.base_offset <= cfg_wdata;
				CFG_STEP_SIZE:   cfg_q.step_size   <= cfg_wdata;
				default: begin
				end
			endcase
		end
	end

	// The slot count is rounded up to whole mask bytes and clamped.
	always_comb begin
		rnd = (32'(cfg_q.slot_count) + 32'd7) & ~32'd7;
		if (rnd < 32'd8) begin
			rnd = 32'd8;
		end
		if (rnd > 32'(MAX_SLOTS)) begin
			rnd = 32'(MAX_SLOTS);
		end
		words_needed = (rnd + 32'd31) >> 5;
		n_slots      = rnd[PW-1:0];
		needed       = words_needed[LW-1:0];
	end

	mbud_front #(
		.LW (LW)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.needed    (needed),
		.din       (din),
		.push      (q_push),
		.push_item (q_push_item),
		.q_full    (q_full)
	);

	mbud_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (q_push),
		.push_item (q_push_item),
		.full      (q_full),
		.pop       (q_pop),
		.pop_item  (q_pop_item),
		.nonempty  (q_nonempty)
	);

	mbud_back #(
		.MAX_SLOTS (MAX_SLOTS),
		.PW        (PW)
	) u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.n_slots (n_slots),
		.q_valid (q_nonempty),
		.q_item  (q_pop_item),
		.q_ready (q_pop),
		.dout    (dout)
	);

endmodule
